/* hdl/epp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epp_pkg - shared types and constants of the e-paper palette packer
// Field widths, colour codes, pigment table and channel widening helpers.
// ----------------------------------------------------------------------------
package epp_pkg;

	localparam int XW       = 10;
	localparam int YW       = 10;
	localparam int RGBW     = 16;
	localparam int CFGW     = 11;
	localparam int IDXW     = 19;
	localparam int CODEW    = 3;
	localparam int CHW      = 8;
	localparam int DISTW    = 18;
	localparam int NPIG     = 4;
	localparam int PIGW     = 2;
	localparam int QDEPTH   = 2;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;
	localparam int SATW     = 13;   // holds any panel maximum up to 4096

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam logic [CFGW-1:0] WIDTH_RST  = 11'd400;
	localparam logic [CFGW-1:0] HEIGHT_RST = 11'd600;

	// register index, taken from paddr[2]
	localparam logic REG_PANEL_WIDTH  = 1'b0;
	localparam logic REG_PANEL_HEIGHT = 1'b1;

	localparam logic [CHW-1:0] GREY_SPREAD    = 8'd32;
	localparam logic [CHW-1:0] LUM_DARK_LIMIT = 8'd70;
	localparam logic [15:0]    LUM_KR = 16'd77;
	localparam logic [15:0]    LUM_KG = 16'd150;
	localparam logic [15:0]    LUM_KB = 16'd29;

	localparam logic [13:0] W5_MUL = 14'd527;
	localparam logic [13:0] W5_ADD = 14'd23;
	localparam logic [13:0] W6_MUL = 14'd259;
	localparam logic [13:0] W6_ADD = 14'd33;

	localparam logic [CODEW-1:0] COLOR_BLACK  = 3'd0;
	localparam logic [CODEW-1:0] COLOR_WHITE  = 3'd1;
	localparam logic [CODEW-1:0] COLOR_YELLOW = 3'd2;
	localparam logic [CODEW-1:0] COLOR_RED    = 3'd3;
	localparam logic [CODEW-1:0] COLOR_UNUSED = 3'd4;
	localparam logic [CODEW-1:0] COLOR_BLUE   = 3'd5;
	localparam logic [CODEW-1:0] COLOR_GREEN  = 3'd6;
	localparam logic [CODEW-1:0] COLOR_SPARE  = 3'd7;

	localparam logic [CHW-1:0]   PIG_R    [NPIG] = '{8'd255, 8'd191, 8'd100, 8'd67};
	localparam logic [CHW-1:0]   PIG_G    [NPIG] = '{8'd243, 8'd0,   8'd64,  8'd138};
	localparam logic [CHW-1:0]   PIG_B    [NPIG] = '{8'd56,  8'd0,   8'd255, 8'd28};
	localparam logic [CODEW-1:0] PIG_CODE [NPIG] = '{COLOR_YELLOW, COLOR_RED,
		COLOR_BLUE, COLOR_GREEN};

	typedef struct packed {
		logic [XW-1:0]  x;
		logic [YW-1:0]  y;
		logic [CHW-1:0] r;
		logic [CHW-1:0] g;
		logic [CHW-1:0] b;
		logic           grey;
	} epp_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} epp_qstat_t;

	function automatic logic [CHW-1:0] widen5(input logic [4:0] c);
		logic [13:0] t;
		t = 14'(c) * W5_MUL + W5_ADD;
		return t[13:6];
	endfunction

	function automatic logic [CHW-1:0] widen6(input logic [5:0] c);
		logic [13:0] t;
		t = 14'(c) * W6_MUL + W6_ADD;
		return t[13:6];
	endfunction

endpackage

/* hdl/epp_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epp_ifs - stream interfaces of the palette packer
// Pixel request channel in, nibble write request channel out.
// ----------------------------------------------------------------------------
interface epp_pix_if;
	import epp_pkg::*;
	logic            valid;
	logic            ready;
	logic [XW-1:0]   pixel_x;
	logic [YW-1:0]   pixel_y;
	logic [RGBW-1:0] pixel_rgb565;

	modport source (output valid, pixel_x, pixel_y, pixel_rgb565, input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_rgb565, output ready);
endinterface

interface epp_nib_if;
	import epp_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDXW-1:0]  byte_index;
	logic             high_nibble;
	logic [CODEW-1:0] color_code;

	modport source (output valid, byte_index, high_nibble, color_code, input ready);
	modport sink   (input valid, byte_index, high_nibble, color_code, output ready);
endinterface

/* hdl/rgb565_to_epaper_palette_packer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_to_epaper_palette_packer_core - RGB565 pixel to e-paper nibble write
// Maps each on-panel pixel to a black/white or pigment code and its frame
// buffer byte and nibble position.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake     | contents
//  ---------+-----------+---------------+------------------------------------
//  pixel    | in        | valid/ready   | pixel_x, pixel_y, pixel_rgb565
//  nib      | out       | valid/ready   | byte_index, high_nibble, color_code
//  apb      | in        | psel/penable  | panel_width @0x0, panel_height @0x4
//
//  One pixel request per cycle unless the queue is full; the front is
//  combinational, the queue and two back stages are registered, and a
//  pixel passes queue, stage 1 and stage 2 before nib.valid. Off-panel
//  pixels are taken and dropped. Reset puts the panel at 400 x 600 and
//  empties queue and back stages. A stall on nib fills the back stages
//  and then the two-entry queue before pixel.ready drops, which depends
//  only on the queue fill.
module rgb565_to_epaper_palette_packer_core #(
	parameter int MAX_WIDTH  = epp_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = epp_pkg::MAX_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [epp_pkg::APB_AW-1:0]   paddr,
	input  logic [epp_pkg::APB_DW-1:0]   pwdata,
	output logic [epp_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	epp_pix_if.sink                      pixel,
	epp_nib_if.source                    nib
);
	import epp_pkg::*;

	localparam logic [SATW-1:0] MAXW = SATW'(MAX_WIDTH);
	localparam logic [SATW-1:0] MAXH = SATW'(MAX_HEIGHT);

	logic [CFGW-1:0] width_q, height_q;
	logic [CFGW-1:0] w_eff, h_eff;
	logic            reg_sel;
	logic            q_push, q_pop;
	epp_item_t       q_wdata, q_rdata;
	epp_qstat_t      qstat;

	// --- configuration registers ------------------------------------------
	// register index is the word address; byte lanes below it are ignored
	assign reg_sel = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_sel)
				REG_PANEL_WIDTH:  width_q  <= pwdata[CFGW-1:0];
				REG_PANEL_HEIGHT: height_q <= pwdata[CFGW-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_PANEL_WIDTH:  prdata = APB_DW'(width_q);
			REG_PANEL_HEIGHT: prdata = APB_DW'(height_q);
		endcase
	end

	// clamp to the panel maximum; the clamped value never exceeds the
	// register, so it still fits its width
	assign w_eff = ({(SATW-CFGW)'(0), width_q} > MAXW)  ? MAXW[CFGW-1:0] : width_q;
	assign h_eff = ({(SATW-CFGW)'(0), height_q} > MAXH) ? MAXH[CFGW-1:0] : height_q;

	// --- datapath ---------------------------------------------------------
	epp_front u_front (
		.pixel (pixel),
		.w_eff (w_eff),
		.h_eff (h_eff),
		.qstat (qstat),
		.push  (q_push),
		.item  (q_wdata)
	);

	epp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.qstat  (qstat)
	);

	epp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.w_eff  (w_eff),
		.qstat  (qstat),
		.item   (q_rdata),
		.pop    (q_pop),
		.nib    (nib)
	);

	// --- checks -----------------------------------------------------------
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !qstat.full)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !qstat.empty)
		else $error("queue read while empty");

	a_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		nib.valid |-> (nib.color_code != COLOR_UNUSED && nib.color_code != COLOR_SPARE))
		else $error("unassigned colour code on output");

	a_push_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (pixel.valid && pixel.ready))
		else $error("queue written without an accepted pixel");

endmodule

/* hdl/epp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epp_front - pixel intake and classification
// Drops pixels off the panel, widens channels and flags grey pixels.
// ----------------------------------------------------------------------------
module epp_front (
	epp_pix_if.sink                     pixel,
	input  logic [epp_pkg::CFGW-1:0]    w_eff,
	input  logic [epp_pkg::CFGW-1:0]    h_eff,
	input  epp_pkg::epp_qstat_t         qstat,
	output logic                        push,
	output epp_pkg::epp_item_t          item
);
	import epp_pkg::*;

	logic           in_range;
	logic [CHW-1:0] r, g, b, hi, lo, spread;

	always_comb begin
		r = widen5(pixel.pixel_rgb565[15:11]);
		g = widen6(pixel.pixel_rgb565[10:5]);
		b = widen5(pixel.pixel_rgb565[4:0]);
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		spread = hi - lo;
	end

	assign in_range = ({1'b0, pixel.pixel_x} < w_eff) && ({1'b0, pixel.pixel_y} < h_eff);

	// off-panel pixels are taken but never queued
	assign pixel.ready = !qstat.full;
	assign push        = pixel.valid && pixel.ready && in_range;

	assign item.x    = pixel.pixel_x;
	assign item.y    = pixel.pixel_y;
	assign item.r    = r;
	assign item.g    = g;
	assign item.b    = b;
	assign item.grey = spread < GREY_SPREAD;

endmodule

/* hdl/epp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epp_queue - short queue between front and back
// Two entry FIFO, full and empty status decoded from a registered count.
// ----------------------------------------------------------------------------
module epp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  epp_pkg::epp_item_t  wdata,
	input  logic                pop,
	output epp_pkg::epp_item_t  rdata,
	output epp_pkg::epp_qstat_t qstat
);
	import epp_pkg::*;

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	epp_item_t       entry_q [QDEPTH];
	logic [PW-1:0]   wptr_q, rptr_q;
	logic [CW-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) entry_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)  rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	assign rdata       = entry_q[rptr_q];
	assign qstat.full  = count_q == CW'(QDEPTH);
	assign qstat.empty = count_q == '0;

endmodule

/* hdl/epp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epp_back - colour decision and address generation
// Stage 1: luminance, pigment distances, byte index. Stage 2: result register.
// ----------------------------------------------------------------------------
module epp_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [epp_pkg::CFGW-1:0]    w_eff,
	input  epp_pkg::epp_qstat_t         qstat,
	input  epp_pkg::epp_item_t          item,
	output logic                        pop,
	epp_nib_if.source                   nib
);
	import epp_pkg::*;

	logic                v_s1, v_s2;
	logic [IDXW-1:0]     idx_s1, idx_s2;
	logic                hi_s1, hi_s2;
	logic                grey_s1, dark_s1;
	logic [DISTW-1:0]    dist_s1 [NPIG];
	logic [CODEW-1:0]    code_s2;

	logic                s1_ready, s2_ready;
	logic [15:0]         lum_sum;
	logic [DISTW-1:0]    pig_dist [NPIG];
	logic [CHW-1:0]      dr, dg, db;
	logic [2*YW-1:0]     prod;
	logic [PIGW-1:0]     best;
	logic [CODEW-1:0]    code;

	assign s2_ready = !v_s2 || nib.ready;
	assign s1_ready = !v_s1 || s2_ready;
	assign pop      = !qstat.empty && s1_ready;

	always_comb begin
		lum_sum = 16'(item.r) * LUM_KR + 16'(item.g) * LUM_KG + 16'(item.b) * LUM_KB;
		for (int p = 0; p < NPIG; p++) begin
			dr = (item.r > PIG_R[p]) ? item.r - PIG_R[p] : PIG_R[p] - item.r;
			dg = (item.g > PIG_G[p]) ? item.g - PIG_G[p] : PIG_G[p] - item.g;
			db = (item.b > PIG_B[p]) ? item.b - PIG_B[p] : PIG_B[p] - item.b;
			pig_dist[p] = DISTW'(16'(dr) * 16'(dr)) + DISTW'(16'(dg) * 16'(dg))
				+ DISTW'(16'(db) * 16'(db));
		end
		// rows are w/2 bytes long, rounded down
		prod = (2*YW)'(item.y) * (2*YW)'(w_eff[CFGW-1:1]);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			idx_s1  <= IDXW'(prod + (2*YW)'(item.x[XW-1:1]));
			hi_s1   <= !item.x[0];
			grey_s1 <= item.grey;
			dark_s1 <= lum_sum[15:8] > LUM_DARK_LIMIT;
			for (int p = 0; p < NPIG; p++) dist_s1[p] <= pig_dist[p];
		end
	end

	// nearest pigment, strict compare keeps the earlier entry on a tie
	always_comb begin
		best = '0;
		for (int p = 1; p < NPIG; p++) begin
			if (dist_s1[p] < dist_s1[best]) best = PIGW'(p);
		end
		if (grey_s1) code = dark_s1 ? COLOR_BLACK : COLOR_WHITE;
		else         code = PIG_CODE[best];
	end

	always_ff @(posedge clk) begin
		if (s2_ready && v_s1) begin
			idx_s2  <= idx_s1;
			hi_s2   <= hi_s1;
			code_s2 <= code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_ready) v_s1 <= pop;
			if (s2_ready) v_s2 <= v_s1;
		end
	end

	assign nib.valid       = v_s2;
	assign nib.byte_index  = idx_s2;
	assign nib.high_nibble = hi_s2;
	assign nib.color_code  = code_s2;

endmodule

/* tb/tb_rgb565_to_epaper_palette_packer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb565_to_epaper_palette_packer_core - palette packer self-checking bench
// Streams pixels through the packer under several panel sizes, predicts each
// nibble write in a scoreboard and compares every returned write field by
// field, with bursty pixel requests and a stalling nibble sink.
// ----------------------------------------------------------------------------
import epp_pkg::*;

typedef struct packed {
	logic [IDXW-1:0]  byte_index;
	logic             high_nibble;
	logic [CODEW-1:0] color_code;
} nibble_write_t;

class nibble_scoreboard;
	int unsigned   panel_w;
	int unsigned   panel_h;
	nibble_write_t pending[$];
	int            errors;

	function new();
		panel_w = WIDTH_RST;
		panel_h = HEIGHT_RST;
		errors  = 0;
	endfunction

	static function int pigment_dist(int r, int g, int b, int pr, int pg, int pb);
		return (r - pr) * (r - pr) + (g - pg) * (g - pg) + (b - pb) * (b - pb);
	endfunction

	function logic [CODEW-1:0] palette_code(logic [RGBW-1:0] rgb);
		int r, g, b, hi, lo, lum, sqd, best_dist;
		logic [CODEW-1:0] best;
		r  = (int'(rgb[15:11]) * 527 + 23) >> 6;
		g  = (int'(rgb[10:5]) * 259 + 33) >> 6;
		b  = (int'(rgb[4:0]) * 527 + 23) >> 6;
		hi = r;
		lo = r;
		if (g > hi) hi = g;
		if (b > hi) hi = b;
		if (g < lo) lo = g;
		if (b < lo) lo = b;
		// near-neutral: inverted luminance threshold
		if (hi - lo < 32) begin
			lum = (77 * r + 150 * g + 29 * b) >> 8;
			return (lum > 70) ? COLOR_BLACK : COLOR_WHITE;
		end
		// nearest pigment, strict compare so the earlier entry keeps a tie
		best_dist = pigment_dist(r, g, b, 255, 243, 56);
		best      = COLOR_YELLOW;
		sqd = pigment_dist(r, g, b, 191, 0, 0);
		if (sqd < best_dist) begin
			best_dist = sqd;
			best      = COLOR_RED;
		end
		sqd = pigment_dist(r, g, b, 100, 64, 255);
		if (sqd < best_dist) begin
			best_dist = sqd;
			best      = COLOR_BLUE;
		end
		sqd = pigment_dist(r, g, b, 67, 138, 28);
		if (sqd < best_dist) begin
			best_dist = sqd;
			best      = COLOR_GREEN;
		end
		return best;
	endfunction

	// returns 1 when the pixel is on the panel and a write is due
	function bit note_pixel(logic [XW-1:0] x, logic [YW-1:0] y, logic [RGBW-1:0] rgb);
		int unsigned   w, h;
		nibble_write_t nw;
		w = (panel_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : panel_w;
		h = (panel_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : panel_h;
		if (x >= w || y >= h)
			return 1'b0;
		nw.byte_index  = IDXW'(y * (w / 2) + x / 2);
		nw.high_nibble = ~x[0];
		nw.color_code  = palette_code(rgb);
		pending.push_back(nw);
		return 1'b1;
	endfunction

	function void check_write(nibble_write_t got);
		nibble_write_t want;
		if (pending.size() == 0) begin
			if (errors < 30)
				$display("%0t: unexpected write, actual idx %0d hi %0d code %0d", $time,
					got.byte_index, got.high_nibble, got.color_code);
			errors++;
			return;
		end
		want = pending.pop_front();
		if (got.byte_index !== want.byte_index) begin
			if (errors < 30)
				$display("%0t: byte_index expected %0d actual %0d", $time,
					want.byte_index, got.byte_index);
			errors++;
		end
		if (got.high_nibble !== want.high_nibble) begin
			if (errors < 30)
				$display("%0t: high_nibble expected %0d actual %0d", $time,
					want.high_nibble, got.high_nibble);
			errors++;
		end
		if (got.color_code !== want.color_code) begin
			if (errors < 30)
				$display("%0t: color_code expected %0d actual %0d", $time,
					want.color_code, got.color_code);
			errors++;
		end
	endfunction
endclass

module tb_rgb565_to_epaper_palette_packer_core;

	localparam logic [APB_AW-1:0] ADDR_PANEL_WIDTH  = {REG_PANEL_WIDTH, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_PANEL_HEIGHT = {REG_PANEL_HEIGHT, 2'b00};
	localparam int PHASE_PIXELS = 95;   // pixel requests per panel setting

	typedef enum {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_e;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	epp_pix_if pix();
	epp_nib_if nib();

	nibble_scoreboard sb = new();
	int burst_left;

	rgb565_to_epaper_palette_packer_core i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pixel   (pix),
		.nib     (nib)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the pipeline locks up.
	initial begin
		#10ms;
		$display("tb_rgb565_to_epaper_palette_packer_core NOT OK");
		$finish;
	end

	// Nibble sink: ready follows a mode that is redrawn at random, from free flow
	// to heavy back-pressure, so stalls hit every stage.
	initial begin
		rx_mode_e mode;
		int       left;
		nib.ready <= 1'b0;
		mode = RX_FLOW;
		left = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = rx_mode_e'($urandom_range(0, 3));
				left = $urandom_range(16, 96);
			end
			left--;
			case (mode)
				RX_FLOW:  nib.ready <= 1'b1;
				RX_LIGHT: nib.ready <= ($urandom_range(0, 3) != 0);
				RX_HEAVY: nib.ready <= ($urandom_range(0, 3) == 0);
				default:  nib.ready <= left[1];
			endcase
		end
	end

	// Result monitor; values read straight after the edge are the sampled ones.
	always @(posedge clk) begin
		if (arst_n && nib.valid && nib.ready)
			sb.check_write({nib.byte_index, nib.high_nibble, nib.color_code});
	end

	// APB transfers leave psel high so back-to-back transfers need no idle;
	// the caller drops psel once it is done.
	task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
	endtask

	task automatic check_reg(input logic [APB_AW-1:0] addr, input int unsigned want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== APB_DW'(want)) begin
			if (sb.errors < 30)
				$display("%0t: register @%0d expected %0d actual %0d", $time, addr,
					want, prdata);
			sb.errors++;
		end
	endtask

	// Panel size may only change with the pipeline empty. Off-panel requests
	// leave nothing to wait for, so allow the pipe depth on top.
	task automatic set_panel(input int unsigned w, input int unsigned h);
		pix.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		apb_write(ADDR_PANEL_WIDTH, APB_DW'(w));
		apb_write(ADDR_PANEL_HEIGHT, APB_DW'(h));
		sb.panel_w = w & 11'h7FF;
		sb.panel_h = h & 11'h7FF;
		check_reg(ADDR_PANEL_WIDTH, sb.panel_w);
		check_reg(ADDR_PANEL_HEIGHT, sb.panel_h);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// One pixel request; bursts of random length separated by random gaps.
	task automatic send_pixel(input logic [XW-1:0] x, input logic [YW-1:0] y,
		input logic [RGBW-1:0] rgb);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				pix.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		pix.valid        <= 1'b1;
		pix.pixel_x      <= x;
		pix.pixel_y      <= y;
		pix.pixel_rgb565 <= rgb;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
		void'(sb.note_pixel(x, y, rgb));
		burst_left--;
	endtask

	// Random pixels, mostly aimed at the panel and its edges; a share of the
	// colours sit near neutral so the grey test and luminance split get work.
	task automatic random_pixels(input int target);
		int unsigned   ew, eh;
		int            sent, c5, c6, c5b;
		logic [XW-1:0] x;
		logic [YW-1:0] y;
		logic [RGBW-1:0] rgb;
		ew = (sb.panel_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : sb.panel_w;
		eh = (sb.panel_h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : sb.panel_h;
		sent = 0;
		while (sent < target) begin
			if (ew > 0 && $urandom_range(0, 3) != 0)
				x = XW'($urandom_range(0, (ew > 1023) ? 1023 : ew));
			else
				x = XW'($urandom());
			if (eh > 0 && $urandom_range(0, 3) != 0)
				y = YW'($urandom_range(0, (eh > 1023) ? 1023 : eh));
			else
				y = YW'($urandom());
			if ($urandom_range(0, 4) < 3) begin
				rgb = RGBW'($urandom());
			end else begin
				c5  = int'($urandom_range(0, 31));
				c6  = 2 * c5 + int'($urandom_range(0, 6)) - 3;
				c5b = c5 + int'($urandom_range(0, 4)) - 2;
				if (c6 < 0) c6 = 0;
				else if (c6 > 63) c6 = 63;
				if (c5b < 0) c5b = 0;
				else if (c5b > 31) c5b = 31;
				rgb = {c5[4:0], c6[5:0], c5b[4:0]};
			end
			send_pixel(x, y, rgb);
			sent++;
		end
	endtask

	initial begin
		arst_n           <= 1'b0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;
		pix.valid        <= 1'b0;
		pix.pixel_x      <= '0;
		pix.pixel_y      <= '0;
		pix.pixel_rgb565 <= '0;
		burst_left = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, at the reset panel of 400 x 600.
		send_pixel(10'd0, 10'd0, 16'h0000);       // black source -> white code
		send_pixel(10'd399, 10'd599, 16'hFFFF);   // last pixel, white -> black
		send_pixel(10'd400, 10'd0, 16'hF800);     // column just off the panel
		send_pixel(10'd0, 10'd600, 16'hF800);     // row just off the panel
		send_pixel(10'd1023, 10'd1023, 16'hFFFF); // field maxima, off panel
		send_pixel(10'd1, 10'd0, 16'hF800);       // pure red, odd column
		send_pixel(10'd2, 10'd1, 16'hFFE0);       // yellow
		send_pixel(10'd3, 10'd2, 16'h001F);       // blue
		send_pixel(10'd398, 10'd3, 16'h07E0);     // green
		send_pixel(10'd5, 10'd4, 16'h4248);       // grey, luminance at the split
		send_pixel(10'd6, 10'd4, 16'h4249);       // grey, just past the split
		send_pixel(10'd7, 10'd4, 16'h4A49);       // grey, a bit brighter
		send_pixel(10'd8, 10'd5, 16'h0100);       // spread exactly at the limit
		send_pixel(10'd9, 10'd5, 16'h00E0);       // spread just under it
		send_pixel(10'd0, 10'd599, 16'hAAAA);
		send_pixel(10'd399, 10'd0, 16'h5555);
		send_pixel(10'd256, 10'd512, 16'h8410);
		random_pixels(PHASE_PIXELS);

		// Panel settings: smallest, maxima, above maxima (saturated), zero
		// width, zero height, odd widths sharing bytes across rows, width one.
		set_panel(2, 1);       random_pixels(PHASE_PIXELS);
		set_panel(1024, 1024); random_pixels(PHASE_PIXELS);
		set_panel(2047, 2047); random_pixels(PHASE_PIXELS);
		set_panel(0, 7);       random_pixels(PHASE_PIXELS);
		set_panel(9, 0);       random_pixels(PHASE_PIXELS);
		set_panel(3, 5);       random_pixels(PHASE_PIXELS);
		set_panel(1025, 1023); random_pixels(PHASE_PIXELS);
		set_panel(1, 4);       random_pixels(PHASE_PIXELS);
		set_panel(17, 1024);   random_pixels(PHASE_PIXELS);
		set_panel($urandom_range(2, 48), $urandom_range(1, 48));
		random_pixels(PHASE_PIXELS);
		set_panel($urandom_range(2, 48), $urandom_range(1, 48));
		random_pixels(PHASE_PIXELS);
		set_panel($urandom_range(0, 2047), $urandom_range(0, 2047));
		random_pixels(PHASE_PIXELS);

		pix.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb_rgb565_to_epaper_palette_packer_core OK");
		else
			$display("tb_rgb565_to_epaper_palette_packer_core NOT OK");
		$finish;
	end

endmodule
